/* sv/lfu_page_cache_directory_defines.svh */
// ----------------------------------------------------------------------------
// LFU page cache directory assertion macros
// Shared assertion forms for the checker of the page cache directory.
// ----------------------------------------------------------------------------
`ifndef LFU_PAGE_CACHE_DIRECTORY_DEFINES_SVH
`define LFU_PAGE_CACHE_DIRECTORY_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LFU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("LFU directory assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LFU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("LFU directory assertion failed");

`endif

/* sv/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// LFU page cache directory package
// Field widths, result packing and the entry evaluation result type.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int KEY_W        = 32;
   localparam int CSR_W        = 4;
   localparam logic [CSR_W-1:0] CSR_RESET = 4'd2;
   localparam int SLOT_OUT_W   = 3;

   localparam int RSP_HIT_BIT   = 0;
   localparam int RSP_SLOT_LSB  = 1;
   localparam int RSP_EV_BIT    = RSP_SLOT_LSB + SLOT_OUT_W;
   localparam int RSP_EVKEY_LSB = RSP_EV_BIT + 1;
   localparam int RSP_FIELDS_W  = RSP_EVKEY_LSB + KEY_W;
   localparam int RSP_W         = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W     = RSP_W - RSP_FIELDS_W;

   typedef struct packed {
      logic is_match;
      logic is_better;
      logic rank_dec;
   } lfu_cmp_type;

endpackage

/* sv/lfu_page_cache_directory.sv */
// ----------------------------------------------------------------------------
// LFU page cache directory
// A fully associative directory of page keys with least-frequently-used
// replacement, ties going to the oldest entry of the lowest use count. Each
// request transaction returns one response transaction giving hit, the slot
// that now holds the key, and the evicted key when a miss forced an eviction.
// After a request is accepted, the sequencer walks the entry memory once to
// search for the key, a free slot and the victim, decides, then walks it
// again to renumber the ages and write the chosen slot, all through one
// shared entry evaluation unit. The request channel is ready only between
// requests; a finished response waits in an output register while the next
// request is taken. The capacity register must be written only between
// requests; the block itself does not enforce this. Its value is clamped to
// 1..CAPACITY.
// ----------------------------------------------------------------------------
module lfu_page_cache_directory
   import lfu_pkg::*;
#(
   parameter int CAPACITY   = 8,
   parameter int COUNT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [KEY_W-1:0] req_tdata,   // [31:0] page_key
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // [0] hit, [3:1] entry_slot, [4] evicted,
                                          // [36:5] evicted_key, [39:37] zero
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data     // [3:0] capacity_in_use
);

   localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OCC_W  = $clog2(CAPACITY + 1);
   localparam int CAPW   = (OCC_W > CSR_W) ? OCC_W : CSR_W;
   localparam logic [OCC_W-1:0]  CAP_OCC  = OCC_W'(CAPACITY);
   localparam logic [CAPW-1:0]   CAP_MAX  = CAPW'(CAPACITY);
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(CAPACITY - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_UPDATE,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [CSR_W-1:0]      csr_ff, csr_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [OCC_W-1:0]      idx_ff, idx_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [SLOT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                  found_ff, found_in;
   logic                  free_ff, free_in;
   logic                  have_ff, have_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;

   logic [KEY_W-1:0]      key_ff, key_in;
   logic [SLOT_W-1:0]     match_slot_ff, match_slot_in;
   logic [COUNT_BITS-1:0] match_cnt_ff, match_cnt_in;
   logic [SLOT_W-1:0]     match_rank_ff, match_rank_in;
   logic [SLOT_W-1:0]     free_slot_ff, free_slot_in;
   logic [SLOT_W-1:0]     vic_slot_ff, vic_slot_in;
   logic [COUNT_BITS-1:0] vic_cnt_ff, vic_cnt_in;
   logic [SLOT_W-1:0]     vic_rank_ff, vic_rank_in;
   logic [KEY_W-1:0]      vic_key_ff, vic_key_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic                  drop_en_ff, drop_en_in;
   logic [SLOT_W-1:0]     drop_rank_ff, drop_rank_in;
   logic [COUNT_BITS-1:0] new_cnt_ff, new_cnt_in;
   logic [SLOT_W-1:0]     new_rank_ff, new_rank_in;
   logic                  hit_ff, hit_in;
   logic                  ev_ff, ev_in;
   logic [KEY_W-1:0]      ev_key_ff, ev_key_in;
   logic [RSP_W-1:0]      rsp_tdata_ff, rsp_tdata_in;

   logic                  rd_en;
   logic [SLOT_W-1:0]     rd_addr;
   logic                  rd_valid;
   logic [KEY_W-1:0]      rd_key;
   logic [COUNT_BITS-1:0] rd_cnt;
   logic [SLOT_W-1:0]     rd_rank;
   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_addr;
   logic [KEY_W-1:0]      wr_key;
   logic [COUNT_BITS-1:0] wr_cnt;
   logic [SLOT_W-1:0]     wr_rank;
   logic [CAPW-1:0]       eff_cap;
   lfu_cmp_type           cmp;

   lfu_dir_store #(
      .CAPACITY   (CAPACITY),
      .COUNT_BITS (COUNT_BITS),
      .SLOT_W     (SLOT_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_valid (rd_valid),
      .rd_key   (rd_key),
      .rd_cnt   (rd_cnt),
      .rd_rank  (rd_rank),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_cnt   (wr_cnt),
      .wr_rank  (wr_rank)
   );

   lfu_entry_unit #(
      .COUNT_BITS (COUNT_BITS),
      .SLOT_W     (SLOT_W)
   ) u_entry (
      .req_key   (key_ff),
      .ent_valid (rd_valid),
      .ent_key   (rd_key),
      .ent_cnt   (rd_cnt),
      .ent_rank  (rd_rank),
      .best_have (have_ff),
      .best_cnt  (vic_cnt_ff),
      .best_rank (vic_rank_ff),
      .drop_rank (drop_rank_ff),
      .is_target (rd_idx_ff == slot_ff),
      .result    (cmp)
   );

   always_comb begin
      eff_cap = CAPW'(csr_ff);
      if (eff_cap == '0) begin
         eff_cap = CAPW'(1);
      end else if (eff_cap > CAP_MAX) begin
         eff_cap = CAP_MAX;
      end
   end

   always_comb begin
      state_in      = state_ff;
      csr_in        = csr_ff;
      occ_in        = occ_ff;
      idx_in        = idx_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      found_in      = found_ff;
      free_in       = free_ff;
      have_in       = have_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      key_in        = key_ff;
      match_slot_in = match_slot_ff;
      match_cnt_in  = match_cnt_ff;
      match_rank_in = match_rank_ff;
      free_slot_in  = free_slot_ff;
      vic_slot_in   = vic_slot_ff;
      vic_cnt_in    = vic_cnt_ff;
      vic_rank_in   = vic_rank_ff;
      vic_key_in    = vic_key_ff;
      slot_in       = slot_ff;
      drop_en_in    = drop_en_ff;
      drop_rank_in  = drop_rank_ff;
      new_cnt_in    = new_cnt_ff;
      new_rank_in   = new_rank_ff;
      hit_in        = hit_ff;
      ev_in         = ev_ff;
      ev_key_in     = ev_key_ff;
      rsp_tdata_in  = rsp_tdata_ff;

      rd_en   = 1'b0;
      rd_addr = idx_ff[SLOT_W-1:0];
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_key  = rd_key;
      wr_cnt  = rd_cnt;
      wr_rank = rd_rank - SLOT_W'(1);

      if (csr_valid) begin
         csr_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               key_in   = req_tdata;
               idx_in   = '0;
               found_in = 1'b0;
               free_in  = 1'b0;
               have_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_ff < CAP_OCC) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff[SLOT_W-1:0];
               idx_in    = idx_ff + OCC_W'(1);
            end
            if (rd_vld_ff) begin
               if (cmp.is_match && !found_ff) begin
                  found_in      = 1'b1;
                  match_slot_in = rd_idx_ff;
                  match_cnt_in  = rd_cnt;
                  match_rank_in = rd_rank;
               end
               if (!rd_valid && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = rd_idx_ff;
               end
               if (cmp.is_better) begin
                  have_in     = 1'b1;
                  vic_slot_in = rd_idx_ff;
                  vic_cnt_in  = rd_cnt;
                  vic_rank_in = rd_rank;
                  vic_key_in  = rd_key;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            idx_in    = '0;
            ev_key_in = '0;
            if (found_ff) begin
               hit_in       = 1'b1;
               ev_in        = 1'b0;
               slot_in      = match_slot_ff;
               drop_en_in   = 1'b1;
               drop_rank_in = match_rank_ff;
               new_cnt_in   = (&match_cnt_ff) ? match_cnt_ff
                                              : match_cnt_ff + COUNT_BITS'(1);
               new_rank_in  = SLOT_W'(occ_ff - OCC_W'(1));
            end else if (CAPW'(occ_ff) < eff_cap) begin
               hit_in       = 1'b0;
               ev_in        = 1'b0;
               slot_in      = free_slot_ff;
               drop_en_in   = 1'b0;
               new_cnt_in   = COUNT_BITS'(1);
               new_rank_in  = SLOT_W'(occ_ff);
               occ_in       = occ_ff + OCC_W'(1);
            end else begin
               hit_in       = 1'b0;
               ev_in        = 1'b1;
               ev_key_in    = vic_key_ff;
               slot_in      = vic_slot_ff;
               drop_en_in   = 1'b1;
               drop_rank_in = vic_rank_ff;
               new_cnt_in   = COUNT_BITS'(1);
               new_rank_in  = SLOT_W'(occ_ff - OCC_W'(1));
            end
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (idx_ff < CAP_OCC) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff[SLOT_W-1:0];
               idx_in    = idx_ff + OCC_W'(1);
            end
            if (rd_vld_ff) begin
               if (rd_idx_ff == slot_ff) begin
                  wr_en   = 1'b1;
                  wr_key  = key_ff;
                  wr_cnt  = new_cnt_ff;
                  wr_rank = new_rank_ff;
               end else if (drop_en_ff && cmp.rank_dec) begin
                  wr_en = 1'b1;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {RSP_PAD_W'(0), ev_key_ff, ev_ff,
                                SLOT_OUT_W'(slot_ff), hit_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         csr_ff        <= CSR_RESET;
         occ_ff        <= '0;
         idx_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         free_ff       <= 1'b0;
         have_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         csr_ff        <= csr_in;
         occ_ff        <= occ_in;
         idx_ff        <= idx_in;
         rd_vld_ff     <= rd_vld_in;
         found_ff      <= found_in;
         free_ff       <= free_in;
         have_ff       <= have_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rd_idx_ff     <= rd_idx_in;
      key_ff        <= key_in;
      match_slot_ff <= match_slot_in;
      match_cnt_ff  <= match_cnt_in;
      match_rank_ff <= match_rank_in;
      free_slot_ff  <= free_slot_in;
      vic_slot_ff   <= vic_slot_in;
      vic_cnt_ff    <= vic_cnt_in;
      vic_rank_ff   <= vic_rank_in;
      vic_key_ff    <= vic_key_in;
      slot_ff       <= slot_in;
      drop_en_ff    <= drop_en_in;
      drop_rank_ff  <= drop_rank_in;
      new_cnt_ff    <= new_cnt_in;
      new_rank_ff   <= new_rank_in;
      hit_ff        <= hit_in;
      ev_ff         <= ev_in;
      ev_key_ff     <= ev_key_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign csr_ready  = 1'b1;

endmodule

/* sv/lfu_entry_unit.sv */
// ----------------------------------------------------------------------------
// LFU entry evaluation unit
// Compares one directory entry against the request key, the current victim
// candidate and the rank being removed from the age order.
// ----------------------------------------------------------------------------
module lfu_entry_unit
   import lfu_pkg::*;
#(
   parameter int COUNT_BITS = 16,
   parameter int SLOT_W     = 3
) (
   input  logic [KEY_W-1:0]      req_key,
   input  logic                  ent_valid,
   input  logic [KEY_W-1:0]      ent_key,
   input  logic [COUNT_BITS-1:0] ent_cnt,
   input  logic [SLOT_W-1:0]     ent_rank,
   input  logic                  best_have,
   input  logic [COUNT_BITS-1:0] best_cnt,
   input  logic [SLOT_W-1:0]     best_rank,
   input  logic [SLOT_W-1:0]     drop_rank,
   input  logic                  is_target,
   output lfu_cmp_type           result
);

   always_comb begin
      result.is_match  = ent_valid && (ent_key == req_key);
      result.is_better = ent_valid && (!best_have || (ent_cnt < best_cnt) ||
                         ((ent_cnt == best_cnt) && (ent_rank < best_rank)));
      result.rank_dec  = ent_valid && !is_target && (ent_rank > drop_rank);
   end

endmodule

/* sv/lfu_dir_store.sv */
// ----------------------------------------------------------------------------
// LFU directory store
// Entry memory holding key, use count and age rank, with one write port and
// one registered read port, plus per-entry valid flags.
// ----------------------------------------------------------------------------
module lfu_dir_store
   import lfu_pkg::*;
#(
   parameter int CAPACITY   = 8,
   parameter int COUNT_BITS = 16,
   parameter int SLOT_W     = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [SLOT_W-1:0]     rd_addr,
   output logic                  rd_valid,
   output logic [KEY_W-1:0]      rd_key,
   output logic [COUNT_BITS-1:0] rd_cnt,
   output logic [SLOT_W-1:0]     rd_rank,
   input  logic                  wr_en,
   input  logic [SLOT_W-1:0]     wr_addr,
   input  logic [KEY_W-1:0]      wr_key,
   input  logic [COUNT_BITS-1:0] wr_cnt,
   input  logic [SLOT_W-1:0]     wr_rank
);

   localparam int ENT_W = KEY_W + COUNT_BITS + SLOT_W;

   logic [ENT_W-1:0]    mem_ff [CAPACITY];
   logic [CAPACITY-1:0] valid_ff;
   logic [ENT_W-1:0]    rdata_ff;
   logic                rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_key, wr_cnt, wr_rank};
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_valid = rvalid_ff;
   assign rd_key   = rdata_ff[ENT_W-1 -: KEY_W];
   assign rd_cnt   = rdata_ff[SLOT_W +: COUNT_BITS];
   assign rd_rank  = rdata_ff[SLOT_W-1:0];

endmodule

/* sv/lfu_page_cache_directory_checker.sv */
// ----------------------------------------------------------------------------
// LFU page cache directory checker
// Port-level assertions on the directory, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "lfu_page_cache_directory_defines.svh"

module lfu_page_cache_directory_checker
   import lfu_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   `LFU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

   `LFU_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

   `LFU_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_tvalid && req_tready,
      !$rose(rsp_tvalid))

   `LFU_ASSERT_IMPL(a_hit_no_evict, clock, reset, rsp_tvalid,
      !(rsp_tdata[RSP_HIT_BIT] && rsp_tdata[RSP_EV_BIT]))

   `LFU_ASSERT_IMPL(a_evkey_zero, clock, reset, rsp_tvalid && !rsp_tdata[RSP_EV_BIT],
      rsp_tdata[RSP_EVKEY_LSB +: KEY_W] == '0)

endmodule

bind lfu_page_cache_directory lfu_page_cache_directory_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* sim/lfu_page_cache_directory_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU page cache directory testbench
// Sends page request transactions from a queue, predicts every response with
// a behavioral model of the directory, and compares the response transactions
// field by field. A directed opening covers key extremes, a long run of hits
// and a lowered capacity. Random phases then sweep the capacity setting and
// several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module lfu_page_cache_directory_tb;
   import lfu_pkg::*;

   localparam int CAPACITY    = 8;
   localparam int COUNT_BITS  = 16;
   localparam int AGE_W       = $clog2(CAPACITY);
   localparam int FILL_W      = $clog2(CAPACITY + 1);
   localparam int QUIET_LIMIT = 4000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 190;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [KEY_W-1:0] key;
      bit               drain_first;
   } page_request_type;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  evicted;
      logic [KEY_W-1:0]      evicted_key;
   } page_outcome_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [KEY_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_data   = '0;

   page_request_type pending_pages[$];
   page_outcome_type expected_outcomes[$];
   idle_mode_type    idle_mode = IDLE_NONE;
   int               accept_count = 0;
   int               seen_accepts = 0;
   int               error_count = 0;
   int               quiet_cycles = 0;

   logic                  entry_live [CAPACITY] = '{default: 1'b0};
   logic [KEY_W-1:0]      entry_page [CAPACITY];
   logic [COUNT_BITS-1:0] entry_uses [CAPACITY];
   logic [AGE_W-1:0]      entry_age  [CAPACITY];
   logic [FILL_W-1:0]     live_count = '0;
   logic [CSR_W-1:0]      capacity_reg = CSR_RESET;

   int phase_cap  [PHASES] = '{15, 0, 8, 1, 3, 6, 2, 5};
   int phase_mode [PHASES] = '{0, 1, 2, 3, 3, 2, 1, 0};

   lfu_page_cache_directory #(
      .CAPACITY   (CAPACITY),
      .COUNT_BITS (COUNT_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   task automatic retire_age(input int s);
      for (int i = 0; i < CAPACITY; i++) begin
         if (entry_live[i] && i != s && entry_age[i] > entry_age[s]) begin
            entry_age[i] = entry_age[i] - 1'b1;
         end
      end
   endtask

   task automatic lookup_page(input logic [KEY_W-1:0] key, output page_outcome_type res);
      int  slot;
      int  limit;
      bit  found;
      bit  have;
      slot  = 0;
      found = 1'b0;
      have  = 1'b0;
      res   = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (!found && entry_live[i] && entry_page[i] == key) begin
            slot  = i;
            found = 1'b1;
         end
      end
      limit = (capacity_reg < 1) ? 1 : (capacity_reg > CAPACITY) ? CAPACITY : capacity_reg;
      if (found) begin
         if (entry_uses[slot] != '1) begin
            entry_uses[slot] = entry_uses[slot] + 1'b1;
         end
         retire_age(slot);
         entry_age[slot] = AGE_W'(live_count - 1'b1);
      end else if (live_count < limit) begin
         for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!entry_live[i]) begin
               slot = i;
            end
         end
         entry_live[slot] = 1'b1;
         entry_page[slot] = key;
         entry_uses[slot] = COUNT_BITS'(1);
         entry_age[slot]  = AGE_W'(live_count);
         live_count       = live_count + 1'b1;
      end else begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (entry_live[i] && (!have || entry_uses[i] < entry_uses[slot] ||
                (entry_uses[i] == entry_uses[slot] && entry_age[i] < entry_age[slot]))) begin
               slot = i;
               have = 1'b1;
            end
         end
         res.evicted     = 1'b1;
         res.evicted_key = entry_page[slot];
         retire_age(slot);
         entry_page[slot] = key;
         entry_uses[slot] = COUNT_BITS'(1);
         entry_age[slot]  = AGE_W'(live_count - 1'b1);
      end
      res.hit  = found;
      res.slot = slot[SLOT_OUT_W-1:0];
   endtask

   always @(negedge clock) begin : driver
      bit send_ok;
      bit sink_ok;
      send_ok = 1'b1;
      sink_ok = 1'b1;
      case (idle_mode)
         IDLE_SENDER: begin
            send_ok = $urandom_range(99) < 18;
         end
         IDLE_RECEIVER: begin
            sink_ok = $urandom_range(99) < 18;
         end
         IDLE_BOTH: begin
            send_ok = $urandom_range(99) >= 19;
            sink_ok = $urandom_range(99) >= 19;
         end
         default: ;
      endcase
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= sink_ok;
         if (!req_tvalid || accept_count != seen_accepts) begin
            seen_accepts = accept_count;
            if (pending_pages.size() != 0 && send_ok &&
                (!pending_pages[0].drain_first || expected_outcomes.size() == 0)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_pages[0].key;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      page_outcome_type want;
      page_outcome_type got;
      bit               progress;
      progress = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            lookup_page(pending_pages[0].key, want);
            expected_outcomes = {expected_outcomes, want};
            void'(pending_pages.pop_front());
            accept_count++;
            progress = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            progress        = 1'b1;
            got.hit         = rsp_tdata[RSP_HIT_BIT];
            got.slot        = rsp_tdata[RSP_SLOT_LSB +: SLOT_OUT_W];
            got.evicted     = rsp_tdata[RSP_EV_BIT];
            got.evicted_key = rsp_tdata[RSP_EVKEY_LSB +: KEY_W];
            if (expected_outcomes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response transaction, actual %h", $time, got);
            end else begin
               want = expected_outcomes.pop_front();
               if (got.hit !== want.hit) begin
                  error_count++;
                  $display("%0t: hit expected %0d, actual %0d", $time, want.hit, got.hit);
               end
               if (got.slot !== want.slot) begin
                  error_count++;
                  $display("%0t: entry_slot expected %0d, actual %0d",
                           $time, want.slot, got.slot);
               end
               if (got.evicted !== want.evicted) begin
                  error_count++;
                  $display("%0t: evicted expected %0d, actual %0d",
                           $time, want.evicted, got.evicted);
               end
               if (got.evicted_key !== want.evicted_key) begin
                  error_count++;
                  $display("%0t: evicted_key expected %h, actual %h",
                           $time, want.evicted_key, got.evicted_key);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            progress = 1'b1;
         end
         quiet_cycles = progress ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic queue_page(input logic [KEY_W-1:0] key, input bit drain_first);
      page_request_type item;
      item.key         = key;
      item.drain_first = drain_first;
      pending_pages    = {pending_pages, item};
   endtask

   task automatic wait_until_idle();
      while (pending_pages.size() != 0 || expected_outcomes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_capacity(input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      capacity_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [KEY_W-1:0] pool [12];
      int               pool_n;
      int               pick;
      logic [KEY_W-1:0] key;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset capacity of two: extreme keys, a hit, eviction and a long run of hits.
      queue_page(32'h0000_0000, 1'b0);
      queue_page(32'hFFFF_FFFF, 1'b0);
      queue_page(32'h0000_0000, 1'b0);
      queue_page(32'h1234_5678, 1'b0);
      repeat (16) queue_page(32'h1234_5678, 1'b0);
      queue_page(32'hA5A5_5A5A, 1'b0);
      wait_until_idle();
      write_capacity(4'd8);
      queue_page(32'h0000_0001, 1'b0);
      queue_page(32'h0000_0002, 1'b0);
      queue_page(32'h0000_0004, 1'b0);
      queue_page(32'h0000_0008, 1'b0);
      queue_page(32'h8000_0000, 1'b0);
      wait_until_idle();
      // Capacity now below the occupancy: each miss replaces one entry.
      write_capacity(4'd2);
      queue_page(32'h0F0F_F0F0, 1'b0);
      queue_page(32'h7FFF_FFFF, 1'b0);
      queue_page(32'h1234_5678, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         wait_until_idle();
         write_capacity(CSR_W'(phase_cap[p]));
         idle_mode = idle_mode_type'(phase_mode[p]);
         pool_n = (phase_cap[p] < 1) ? 4 : (phase_cap[p] > CAPACITY) ? CAPACITY + 3 :
                  phase_cap[p] + 3;
         for (int k = 0; k < pool_n; k++) begin
            pool[k] = $urandom;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
               key = pool[$urandom_range(pool_n - 1) < $urandom_range(pool_n - 1) ?
                          $urandom_range(pool_n - 1) : $urandom_range(pool_n - 1)];
            end else if (pick < 93) begin
               key = $urandom;
            end else begin
               key = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            end
            if ($urandom_range(32) == 0) begin
               pool[$urandom_range(pool_n - 1)] = $urandom;
            end
            queue_page(key, $urandom_range(49) == 0);
         end
      end

      wait_until_idle();
      repeat (30) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
